// ===== design/hex_command_parser_fifo_assert.svh =====
// Assertion macros used by the parser top-level design file.
// All checks are clocked on clock and held off while reset is high.
`ifndef HEX_COMMAND_PARSER_FIFO_ASSERT_SVH
`define HEX_COMMAND_PARSER_FIFO_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HCP_CHECK_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hex_command_parser_fifo: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HCP_CHECK_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hex_command_parser_fifo: next-cycle check failed");

`endif

// ===== design/hcp_pkg.sv =====
package hcp_pkg;

   localparam int CMD_W     = 32;
   localparam int NIB_W     = 4;
   localparam int DIGITS    = 8;
   localparam int CNT_W     = 3;
   localparam int OPQ_DEPTH = 2;
   localparam int OPQ_PTR_W = 1;
   localparam int OPQ_CNT_W = 2;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;

   typedef logic [1:0] op_type;
   localparam op_type OP_ACCEPT = 2'd0;
   localparam op_type OP_REJECT = 2'd1;
   localparam op_type OP_PUSH   = 2'd2;
   localparam op_type OP_POP    = 2'd3;

   typedef struct packed {
      op_type             op;
      logic [CMD_W-1:0]   word;
   } cmd_op_type;

   typedef struct packed {
      logic               ok;
      logic [NIB_W-1:0]   nib;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type     res;
      logic [7:0]  diff;
      res  = '0;
      diff = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         diff = c - 8'h30;
         res.ok = 1'b1;
      end else if (c >= 8'h41 && c <= 8'h46) begin
         diff = c - 8'h37;
         res.ok = 1'b1;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         diff = c - 8'h57;
         res.ok = 1'b1;
      end
      res.nib = diff[NIB_W-1:0];
      return res;
   endfunction

endpackage

// ===== design/hcp_channels.sv =====
interface hcp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] char_code;

   modport source (output valid, output action, output char_code, input ready);
   modport sink   (input valid, input action, input char_code, output ready);
endinterface

interface hcp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      char_accepted;
   logic                      popped;
   logic [hcp_pkg::CMD_W-1:0] command_word;
   logic [2:0]                queue_level;

   modport source (output valid, output char_accepted, output popped,
                   output command_word, output queue_level, input ready);
   modport sink   (input valid, input char_accepted, input popped,
                   input command_word, input queue_level, output ready);
endinterface

// ===== design/hcp_front.sv =====
module hcp_front (
   input  logic                clock,
   input  logic                reset,
   hcp_req_if.sink             req,
   output logic                op_valid,
   output hcp_pkg::cmd_op_type op_out,
   input  logic                op_ready
);

   logic [hcp_pkg::CMD_W-1:0] partial_ff, partial_in;
   logic [hcp_pkg::CNT_W-1:0] count_ff, count_in;
   logic [hcp_pkg::CMD_W-1:0] base;
   logic [hcp_pkg::CMD_W-1:0] assembled;
   hcp_pkg::hex_type          hex;
   logic                      is_delim;
   logic                      fire;

   assign req.ready = op_ready;
   assign op_valid  = req.valid;
   assign fire      = req.valid && op_ready;

   always_comb begin
      hex      = hcp_pkg::hex_decode(req.char_code);
      is_delim = (req.char_code == hcp_pkg::CHAR_NEWLINE) ||
                 (req.char_code == hcp_pkg::CHAR_CLOSE);
      // The first digit of a command starts from a clean word.
      base      = (count_ff == '0) ? '0 : partial_ff;
      // Digit n lands in nibble 7-n, which is the bitwise inverse of a 3-bit count.
      assembled = base | (hcp_pkg::CMD_W'(hex.nib) << {~count_ff, 2'b00});

      partial_in  = partial_ff;
      count_in    = count_ff;
      op_out.op   = hcp_pkg::OP_ACCEPT;
      op_out.word = '0;

      if (req.action) begin
         op_out.op = hcp_pkg::OP_POP;
      end else if (is_delim) begin
         if (count_ff != '0) begin
            op_out.op   = hcp_pkg::OP_PUSH;
            op_out.word = partial_ff;
            count_in    = '0;
         end
      end else if (hex.ok) begin
         partial_in = assembled;
         if (count_ff == hcp_pkg::CNT_W'(hcp_pkg::DIGITS - 1)) begin
            op_out.op   = hcp_pkg::OP_PUSH;
            op_out.word = assembled;
            count_in    = '0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end else begin
         op_out.op = hcp_pkg::OP_REJECT;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         count_ff   <= '0;
      end else if (fire) begin
         partial_ff <= partial_in;
         count_ff   <= count_in;
      end
   end

endmodule

// ===== design/hcp_opq.sv =====
module hcp_opq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  hcp_pkg::cmd_op_type push_data,
   output logic                push_ready,
   output logic                pop_valid,
   output hcp_pkg::cmd_op_type pop_data,
   input  logic                pop_ready
);

   hcp_pkg::cmd_op_type           slot_ff [hcp_pkg::OPQ_DEPTH];
   logic [hcp_pkg::OPQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [hcp_pkg::OPQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [hcp_pkg::OPQ_CNT_W-1:0] count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign push_ready = (count_ff != hcp_pkg::OPQ_CNT_W'(hcp_pkg::OPQ_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/hcp_back.sv =====
module hcp_back #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                op_valid,
   input  hcp_pkg::cmd_op_type op_in,
   output logic                op_ready,
   hcp_rsp_if.source           rsp
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [LVL_W-1:0] FULL_LVL = LVL_W'(QUEUE_DEPTH);

   logic [hcp_pkg::CMD_W-1:0] cmd_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]          head_ff, head_in;
   logic [PTR_W-1:0]          tail_ff, tail_in;
   logic [LVL_W-1:0]          level_ff, level_in;
   logic                      do_write;
   logic                      take;

   logic                      rsp_valid_ff;
   logic                      accepted_ff, accepted_in;
   logic                      popped_ff, popped_in;
   logic [hcp_pkg::CMD_W-1:0] word_ff, word_in;
   logic [2:0]                qlevel_ff;

   // The result register frees up when it is empty or being drained.
   assign op_ready = !rsp_valid_ff || rsp.ready;
   assign take     = op_valid && op_ready;

   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      level_in    = level_ff;
      do_write    = 1'b0;
      accepted_in = 1'b0;
      popped_in   = 1'b0;
      word_in     = '0;
      if (take) begin
         unique case (op_in.op)
            hcp_pkg::OP_ACCEPT: begin
               accepted_in = 1'b1;
            end
            hcp_pkg::OP_REJECT: begin
               accepted_in = 1'b0;
            end
            hcp_pkg::OP_PUSH: begin
               // A finished command that finds the queue full is dropped.
               if (level_ff != FULL_LVL) begin
                  do_write    = 1'b1;
                  tail_in     = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
                  level_in    = level_ff + 1'b1;
                  accepted_in = 1'b1;
               end
            end
            hcp_pkg::OP_POP: begin
               if (level_ff != '0) begin
                  popped_in = 1'b1;
                  word_in   = cmd_ff[head_ff];
                  head_in   = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
                  level_in  = level_ff - 1'b1;
               end
            end
            default: begin
               accepted_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         level_ff <= level_in;
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         cmd_ff[tail_ff] <= op_in.word;
      end
      if (take) begin
         accepted_ff <= accepted_in;
         popped_ff   <= popped_in;
         word_ff     <= word_in;
         qlevel_ff   <= 3'(level_in);
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.char_accepted = accepted_ff;
   assign rsp.popped        = popped_ff;
   assign rsp.command_word  = word_ff;
   assign rsp.queue_level   = qlevel_ff;

endmodule

// ===== design/hex_command_parser_fifo.sv =====
// Channel    Role    Transaction
// req_chan   sink    action, char_code: one character or one pop request
// rsp_chan   source  char_accepted, popped, command_word, queue_level
//
// One request is taken every cycle in steady flow; its response passes through the op
// queue and then into the result register before it can be taken.
// The front decodes and assembles digits, a two-entry op queue decouples it from
// the back end, which owns the command FIFO and the result register.
// Reset is synchronous and clears the digit count, all pointers and levels.
// A stalled response holds the back end; the op queue then fills and req_chan.ready drops.
`include "hex_command_parser_fifo_assert.svh"

module hex_command_parser_fifo #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   hcp_req_if.sink    req_chan,
   hcp_rsp_if.source  rsp_chan
);

   logic                front_valid;
   logic                front_ready;
   hcp_pkg::cmd_op_type front_op;
   logic                back_valid;
   logic                back_ready;
   hcp_pkg::cmd_op_type back_op;

   hcp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .op_valid (front_valid),
      .op_out   (front_op),
      .op_ready (front_ready)
   );

   hcp_opq u_opq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_data  (front_op),
      .push_ready (front_ready),
      .pop_valid  (back_valid),
      .pop_data   (back_op),
      .pop_ready  (back_ready)
   );

   hcp_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_valid (back_valid),
      .op_in    (back_op),
      .op_ready (back_ready),
      .rsp      (rsp_chan)
   );

   // Every op executed by the back end shows up as a response in the next cycle.
   `HCP_CHECK_NEXT(a_op_yields_rsp, back_valid && back_ready, rsp_chan.valid)
   // A response is either a parse result or a pop result, never both.
   `HCP_CHECK_NOW(a_one_kind, rsp_chan.valid, !(rsp_chan.popped && rsp_chan.char_accepted))
   // Only a successful pop carries a command word.
   `HCP_CHECK_NOW(a_word_only_on_pop, rsp_chan.valid && !rsp_chan.popped,
                  rsp_chan.command_word == '0)

endmodule
